### rtl/core/wsfd_pkg.sv
package wsfd_pkg;

    localparam int unsigned DataW   = 8;
    localparam int unsigned OpcW    = 4;
    localparam int unsigned EvW     = 2;
    localparam int unsigned LenW    = 64;
    localparam int unsigned MaxLenW = 25;
    localparam int unsigned ExtW    = 4;
    localparam int unsigned KeyIdxW = 2;

    localparam logic [MaxLenW-1:0] MaxLenReset = MaxLenW'(1 << 20);

    // Event codes of a result beat.
    localparam logic [EvW-1:0] EV_DATA     = 2'd0;
    localparam logic [EvW-1:0] EV_EMPTY    = 2'd1;
    localparam logic [EvW-1:0] EV_UNMASKED = 2'd2;
    localparam logic [EvW-1:0] EV_TOOLONG  = 2'd3;

    localparam logic [OpcW-1:0] OPC_CLOSE  = 4'h8;

    // Seven-bit length codes that announce an extended length field.
    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;
    localparam logic [ExtW-1:0] LEN16_BYTES = 4'd2;
    localparam logic [ExtW-1:0] LEN64_BYTES = 4'd8;

    typedef struct packed {
        logic [EvW-1:0]   event_res;
        logic [DataW-1:0] payload_byte;
        logic [OpcW-1:0]  frame_opcode;
        logic             last;
    } t_result;

endpackage

### rtl/core/websocket_frame_deframer.sv
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_data_byte
// result    out        o_out_valid / i_out_ready   o_event_res, o_payload_byte,
//                                                  o_frame_opcode, o_last
// config    in         i_cfg_wr_en (no wait)       i_cfg_wr_data
//
// One byte is taken per cycle while no result beat waits; a byte is held in the input
// register and its result then in the result register. The rate is set by the single
// parse stage between those two registers, both of which advance together.
// Input ready drops only while a result beat waits in the result register.
// Reset clears the parse state and sets the length limit to 1048576.
module websocket_frame_deframer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [wsfd_pkg::DataW-1:0]        i_data_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [wsfd_pkg::EvW-1:0]          o_event_res,
    output logic [wsfd_pkg::DataW-1:0]        o_payload_byte,
    output logic [wsfd_pkg::OpcW-1:0]         o_frame_opcode,
    output logic                              o_last,
    input  logic                              i_cfg_wr_en,
    input  logic [wsfd_pkg::MaxLenW-1:0]      i_cfg_wr_data
);

    logic                              r_in_valid;
    logic [wsfd_pkg::DataW-1:0]        r_in_byte;
    logic [wsfd_pkg::MaxLenW-1:0]      r_max_len;
    logic                              w_step;
    wsfd_pkg::t_result                 w_res;

    assign w_step     = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_max_len  <= wsfd_pkg::MaxLenReset;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    wsfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_max_len   (r_max_len),
        .i_res_pop   (i_out_ready),
        .o_res       (w_res),
        .o_res_valid (o_out_valid)
    );

    assign o_event_res    = w_res.event_res;
    assign o_payload_byte = w_res.payload_byte;
    assign o_frame_opcode = w_res.frame_opcode;
    assign o_last         = w_res.last;

`ifndef SYNTHESIS
    a_event_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res != wsfd_pkg::EV_DATA) |-> o_last)
        else $error("event beat without last mark");

    a_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res != wsfd_pkg::EV_DATA) |-> (o_payload_byte == '0))
        else $error("event beat carries a payload byte");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_step |=> r_in_valid && $stable(r_in_byte))
        else $error("stalled input byte was lost");

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready &&
        ((o_event_res == wsfd_pkg::EV_UNMASKED) || (o_event_res == wsfd_pkg::EV_TOOLONG))
        |=> !o_out_valid)
        else $error("result beat after an error");
`endif

endmodule

### rtl/core/wsfd_parser.sv
module wsfd_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [wsfd_pkg::DataW-1:0]        i_byte,
    input  logic [wsfd_pkg::MaxLenW-1:0]      i_max_len,
    input  logic                              i_res_pop,
    output wsfd_pkg::t_result                 o_res,
    output logic                              o_res_valid
);

    typedef enum logic [2:0] {
        S_HDR0,
        S_HDR1,
        S_EXTLEN,
        S_KEY,
        S_PAYLOAD,
        S_HALT
    } t_state;

    t_state                              r_state, n_state;
    logic [wsfd_pkg::OpcW-1:0]           r_opc, n_opc;
    logic                                r_mask, n_mask;
    logic [wsfd_pkg::LenW-1:0]           r_len, n_len;
    logic [wsfd_pkg::ExtW-1:0]           r_ext, n_ext;
    logic [3:0][7:0]                     r_key, n_key;
    logic [wsfd_pkg::KeyIdxW-1:0]        r_idx, n_idx;
    wsfd_pkg::t_result                   r_res, n_res;
    logic                                r_res_valid, n_produce;

    logic [wsfd_pkg::LenW-1:0]           w_max_len;
    logic                                w_len_done;
    logic                                w_mask_now;
    t_state                              w_end_state;

    assign w_max_len   = {{(wsfd_pkg::LenW - wsfd_pkg::MaxLenW){1'b0}}, i_max_len};
    // A close frame ends the stream once its last result is out.
    assign w_end_state = (r_opc == wsfd_pkg::OPC_CLOSE) ? S_HALT : S_HDR0;

    always_comb begin
        n_state    = r_state;
        n_opc      = r_opc;
        n_mask     = r_mask;
        n_len      = r_len;
        n_ext      = r_ext;
        n_key      = r_key;
        n_idx      = r_idx;
        n_produce  = 1'b0;
        n_res      = '{event_res: wsfd_pkg::EV_DATA, payload_byte: '0,
                       frame_opcode: r_opc, last: 1'b0};
        w_len_done = 1'b0;
        w_mask_now = r_mask;

        case (r_state)
            S_HDR0: begin
                n_opc   = i_byte[wsfd_pkg::OpcW-1:0];
                n_state = S_HDR1;
            end
            S_HDR1: begin
                n_mask     = i_byte[7];
                w_mask_now = i_byte[7];
                n_len      = '0;
                if (i_byte[6:0] == wsfd_pkg::LEN16_CODE) begin
                    n_ext   = wsfd_pkg::LEN16_BYTES;
                    n_state = S_EXTLEN;
                end else if (i_byte[6:0] == wsfd_pkg::LEN64_CODE) begin
                    n_ext   = wsfd_pkg::LEN64_BYTES;
                    n_state = S_EXTLEN;
                end else begin
                    n_len      = {{(wsfd_pkg::LenW - 7){1'b0}}, i_byte[6:0]};
                    w_len_done = 1'b1;
                end
            end
            S_EXTLEN: begin
                n_len      = {r_len[wsfd_pkg::LenW-9:0], i_byte};
                n_ext      = r_ext - 1'b1;
                w_len_done = (n_ext == '0);
            end
            S_KEY: begin
                // Key byte zero sits in the top byte of the key word.
                n_key[~r_idx] = i_byte;
                n_idx         = r_idx + 1'b1;
                if (r_idx == '1) begin
                    if (r_len > w_max_len) begin
                        n_produce     = 1'b1;
                        n_res.event_res = wsfd_pkg::EV_TOOLONG;
                        n_res.last    = 1'b1;
                        n_state       = S_HALT;
                    end else if (r_len == '0) begin
                        n_produce     = 1'b1;
                        n_res.event_res = wsfd_pkg::EV_EMPTY;
                        n_res.last    = 1'b1;
                        n_state       = w_end_state;
                    end else begin
                        n_state = S_PAYLOAD;
                    end
                end
            end
            S_PAYLOAD: begin
                n_idx              = r_idx + 1'b1;
                n_len              = r_len - 1'b1;
                n_produce          = 1'b1;
                n_res.payload_byte = i_byte ^ r_key[~r_idx];
                n_res.last         = (r_len == wsfd_pkg::LenW'(1));
                if (n_res.last) begin
                    n_state = w_end_state;
                end
            end
            S_HALT: begin
                n_state = S_HALT;
            end
            default: begin
                n_state = S_HDR0;
            end
        endcase

        // The length field is complete: an unmasked frame stops the stream here.
        if (w_len_done) begin
            if (!w_mask_now) begin
                n_produce       = 1'b1;
                n_res.event_res = wsfd_pkg::EV_UNMASKED;
                n_res.last      = 1'b1;
                n_state         = S_HALT;
            end else begin
                n_state = S_KEY;
                n_idx   = '0;
                n_key   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HDR0;
            r_opc       <= '0;
            r_mask      <= 1'b0;
            r_len       <= '0;
            r_ext       <= '0;
            r_key       <= '0;
            r_idx       <= '0;
            r_res       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
            if (i_step) begin
                r_state     <= n_state;
                r_opc       <= n_opc;
                r_mask      <= n_mask;
                r_len       <= n_len;
                r_ext       <= n_ext;
                r_key       <= n_key;
                r_idx       <= n_idx;
                r_res       <= n_res;
                r_res_valid <= n_produce;
            end
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

### verif/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;

    localparam int StallLimit  = 10000;
    localparam int DrainCycles = 10;
    localparam int ReportLimit = 10;
    localparam int ChunkBytes  = 500;
    localparam int SettleWait  = 4;

    localparam logic [wsfd_pkg::OpcW-1:0] OPC_CONT   = 4'h0;
    localparam logic [wsfd_pkg::OpcW-1:0] OPC_TEXT   = 4'h1;
    localparam logic [wsfd_pkg::OpcW-1:0] OPC_BINARY = 4'h2;
    localparam logic [wsfd_pkg::OpcW-1:0] OPC_PING   = 4'h9;

    localparam logic [wsfd_pkg::MaxLenW-1:0] LimitTop     = 25'd16777216;
    localparam logic [wsfd_pkg::MaxLenW-1:0] LimitAllOnes = '1;

    typedef enum logic [1:0] {FORM_7, FORM_16, FORM_64} t_len_form;
    typedef enum logic [2:0] {
        AWAIT_HDR0, AWAIT_HDR1, AWAIT_EXTLEN, AWAIT_KEY, AWAIT_PAYLOAD
    } t_parse_phase;
    typedef enum logic [1:0] {
        STOP_UNMASKED, STOP_TOO_LONG, STOP_CLOSE_DATA, STOP_CLOSE_EMPTY
    } t_stop_cause;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [wsfd_pkg::DataW-1:0]   i_data_byte = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [wsfd_pkg::EvW-1:0]     o_event_res;
    logic [wsfd_pkg::DataW-1:0]   o_payload_byte;
    logic [wsfd_pkg::OpcW-1:0]    o_frame_opcode;
    logic                         o_last;
    logic                         i_cfg_wr_en = 1'b0;
    logic [wsfd_pkg::MaxLenW-1:0] i_cfg_wr_data = '0;

    websocket_frame_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_payload_byte (o_payload_byte),
        .o_frame_opcode (o_frame_opcode),
        .o_last         (o_last),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    // Parser state mirrored by the testbench.
    t_parse_phase                 parse_phase = AWAIT_HDR0;
    logic [wsfd_pkg::OpcW-1:0]    cur_opcode = '0;
    logic                         frame_masked = 1'b0;
    logic [wsfd_pkg::LenW-1:0]    bytes_left = '0;
    logic [wsfd_pkg::ExtW-1:0]    ext_left = '0;
    logic [31:0]                  key_word = '0;
    logic [wsfd_pkg::KeyIdxW-1:0] key_pos = '0;
    logic                         stream_stopped = 1'b0;
    logic [wsfd_pkg::MaxLenW-1:0] len_limit = wsfd_pkg::MaxLenReset;

    wsfd_pkg::t_result deframed_beats[$];
    wsfd_pkg::t_result want_beat;
    int      beats_sent = 0;
    int      fail_count = 0;
    int      stall_cycles = 0;
    logic    steady = 1'b0;

    always #5 i_clk = ~i_clk;

    function automatic bit close_length_field(output wsfd_pkg::t_result res);
        res = '0;
        if (!frame_masked) begin
            res.event_res    = wsfd_pkg::EV_UNMASKED;
            res.frame_opcode = cur_opcode;
            res.last         = 1'b1;
            stream_stopped   = 1'b1;
            return 1'b1;
        end
        parse_phase = AWAIT_KEY;
        key_pos     = '0;
        key_word    = '0;
        return 1'b0;
    endfunction

    function automatic bit deframe_byte(input logic [wsfd_pkg::DataW-1:0] b,
                                        output wsfd_pkg::t_result res);
        logic [wsfd_pkg::DataW-1:0] key_byte;
        res = '0;
        if (stream_stopped)
            return 1'b0;
        case (parse_phase)
            AWAIT_HDR0: begin
                cur_opcode  = b[wsfd_pkg::OpcW-1:0];
                parse_phase = AWAIT_HDR1;
                return 1'b0;
            end
            AWAIT_HDR1: begin
                frame_masked = b[7];
                bytes_left   = '0;
                if (b[6:0] == wsfd_pkg::LEN16_CODE || b[6:0] == wsfd_pkg::LEN64_CODE) begin
                    ext_left    = (b[6:0] == wsfd_pkg::LEN16_CODE) ?
                                  wsfd_pkg::LEN16_BYTES : wsfd_pkg::LEN64_BYTES;
                    parse_phase = AWAIT_EXTLEN;
                    return 1'b0;
                end
                bytes_left = wsfd_pkg::LenW'(b[6:0]);
                return close_length_field(res);
            end
            AWAIT_EXTLEN: begin
                bytes_left = {bytes_left[wsfd_pkg::LenW-9:0], b};
                ext_left   = ext_left - 1'b1;
                if (ext_left != '0)
                    return 1'b0;
                return close_length_field(res);
            end
            AWAIT_KEY: begin
                key_word[8*(3-int'(key_pos)) +: 8] = b;
                if (key_pos != 2'd3) begin
                    key_pos = key_pos + 1'b1;
                    return 1'b0;
                end
                key_pos          = '0;
                res.frame_opcode = cur_opcode;
                res.last         = 1'b1;
                if (bytes_left > wsfd_pkg::LenW'(len_limit)) begin
                    res.event_res  = wsfd_pkg::EV_TOOLONG;
                    stream_stopped = 1'b1;
                    return 1'b1;
                end
                if (bytes_left == '0) begin
                    res.event_res = wsfd_pkg::EV_EMPTY;
                    if (cur_opcode == wsfd_pkg::OPC_CLOSE)
                        stream_stopped = 1'b1;
                    parse_phase = AWAIT_HDR0;
                    return 1'b1;
                end
                parse_phase = AWAIT_PAYLOAD;
                return 1'b0;
            end
            default: begin
                key_byte         = key_word[8*(3-int'(key_pos)) +: 8];
                key_pos          = key_pos + 1'b1;
                bytes_left       = bytes_left - 1'b1;
                res.event_res    = wsfd_pkg::EV_DATA;
                res.payload_byte = b ^ key_byte;
                res.frame_opcode = cur_opcode;
                res.last         = (bytes_left == '0);
                if (res.last) begin
                    if (cur_opcode == wsfd_pkg::OPC_CLOSE)
                        stream_stopped = 1'b1;
                    parse_phase = AWAIT_HDR0;
                end
                return 1'b1;
            end
        endcase
    endfunction

    // Result side: random back-pressure and in-order comparison.
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 30);
        if (o_out_valid && i_out_ready) begin
            if (deframed_beats.size() == 0) begin
                fail_count++;
                if (fail_count <= ReportLimit)
                    $display("%0t: unexpected beat ev=%0d byte=%02h opc=%0h last=%0b",
                             $realtime, o_event_res, o_payload_byte, o_frame_opcode, o_last);
            end else begin
                want_beat = deframed_beats.pop_front();
                if (o_event_res !== want_beat.event_res
                        || o_payload_byte !== want_beat.payload_byte
                        || o_frame_opcode !== want_beat.frame_opcode
                        || o_last !== want_beat.last) begin
                    fail_count++;
                    if (fail_count <= ReportLimit) begin
                        $display("%0t: beat mismatch: expected ev=%0d byte=%02h opc=%0h last=%0b",
                                 $realtime, want_beat.event_res, want_beat.payload_byte,
                                 want_beat.frame_opcode, want_beat.last);
                        $display("    got ev=%0d byte=%02h opc=%0h last=%0b",
                                 o_event_res, o_payload_byte, o_frame_opcode, o_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
            $display("** websocket_frame_deframer: FAILED **");
            $finish;
        end
    end

    // Must be entered right after a rising edge; returns at the edge that accepts the byte
    // with valid still high, so the caller drives valid again in the same step.
    task automatic send_byte(input logic [wsfd_pkg::DataW-1:0] b);
        wsfd_pkg::t_result res;
        while (!steady && $urandom_range(0, 99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
        if (deframe_byte(b, res))
            deframed_beats.insert(deframed_beats.size(), res);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (deframed_beats.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_length_limit(input logic [wsfd_pkg::MaxLenW-1:0] limit);
        wait_drained();
        // Header and key bytes leave no result, so let the pipeline settle.
        repeat (SettleWait) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= limit;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        len_limit = limit;
    endtask

    function automatic t_len_form pick_form(input logic [wsfd_pkg::LenW-1:0] len);
        int pick;
        pick = $urandom_range(0, 99);
        if (len <= 125)
            return (pick < 70) ? FORM_7 : (pick < 85) ? FORM_16 : FORM_64;
        if (len <= 65535)
            return (pick < 50) ? FORM_16 : FORM_64;
        return FORM_64;
    endfunction

    task automatic send_frame(input logic [3:0] flags, input logic [wsfd_pkg::OpcW-1:0] opcode,
                              input logic masked, input logic [wsfd_pkg::LenW-1:0] len,
                              input t_len_form form);
        logic [6:0]  code;
        logic [31:0] key;
        key  = $urandom;
        code = (form == FORM_16) ? wsfd_pkg::LEN16_CODE :
               (form == FORM_64) ? wsfd_pkg::LEN64_CODE : len[6:0];
        send_byte({flags, opcode});
        send_byte({masked, code});
        if (form == FORM_16) begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end else if (form == FORM_64) begin
            for (int i = 7; i >= 0; i--)
                send_byte(len[8*i +: 8]);
        end
        if (!masked)
            return;
        for (int i = 3; i >= 0; i--)
            send_byte(key[8*i +: 8]);
        if (len > wsfd_pkg::LenW'(len_limit))
            return;
        for (longint unsigned n = 0; n < len; n++)
            send_byte(wsfd_pkg::DataW'($urandom_range(0, 255)));
    endtask

    // Masked frame with any opcode but close and a length that fits the current limit.
    task automatic send_random_frame();
        logic [wsfd_pkg::OpcW-1:0] opcode;
        logic [wsfd_pkg::LenW-1:0] len;
        int                        pick;
        do opcode = wsfd_pkg::OpcW'($urandom_range(0, 15));
        while (opcode == wsfd_pkg::OPC_CLOSE);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            len = '0;
        else if (pick < 80)
            len = wsfd_pkg::LenW'($urandom_range(1, 16));
        else if (pick < 95)
            len = wsfd_pkg::LenW'($urandom_range(17, 130));
        else
            len = wsfd_pkg::LenW'($urandom_range(131, 300));
        if (len > wsfd_pkg::LenW'(len_limit))
            len = wsfd_pkg::LenW'($urandom_range(0, int'(len_limit)));
        send_frame(4'($urandom_range(0, 15)), opcode, 1'b1, len, pick_form(len));
    endtask

    task automatic test_directed_frames();
        send_frame(4'h8, OPC_TEXT, 1'b1, '0, FORM_7);
        send_frame(4'hF, 4'hF, 1'b1, wsfd_pkg::LenW'(2), FORM_16);
        send_frame(4'h0, OPC_CONT, 1'b1, wsfd_pkg::LenW'(1), FORM_64);
    endtask

    task automatic test_length_limits();
        logic [wsfd_pkg::MaxLenW-1:0] limit;
        set_length_limit('0);
        send_frame(4'h8, OPC_BINARY, 1'b1, '0, FORM_7);
        send_frame(4'h8, OPC_BINARY, 1'b1, '0, FORM_16);
        send_frame(4'h8, OPC_BINARY, 1'b1, '0, FORM_64);
        // A frame exactly at the limit is still accepted.
        limit = wsfd_pkg::MaxLenW'($urandom_range(1, 8));
        set_length_limit(limit);
        send_frame(4'h8, OPC_PING, 1'b1, wsfd_pkg::LenW'(limit),
                   pick_form(wsfd_pkg::LenW'(limit)));
        set_length_limit(LimitTop);
        send_random_frame();
        set_length_limit(LimitAllOnes);
        send_random_frame();
    endtask

    task automatic run_random_chunk(input logic [wsfd_pkg::MaxLenW-1:0] limit,
                                    input logic quiet);
        int target;
        set_length_limit(limit);
        steady <= quiet;
        target = beats_sent + ChunkBytes;
        while (beats_sent < target)
            send_random_frame();
    endtask

    task automatic test_random_stream();
        run_random_chunk(wsfd_pkg::MaxLenW'($urandom_range(1, 40)), 1'b0);
        run_random_chunk(LimitTop, 1'b0);
        run_random_chunk(LimitAllOnes, 1'b1);
        run_random_chunk(wsfd_pkg::MaxLenW'($urandom_range(100, 300)), 1'b0);
        steady <= 1'b0;
    endtask

    // The parser stops for good here, so this can only come last.
    task automatic test_stream_stop();
        t_stop_cause               cause;
        logic [wsfd_pkg::LenW-1:0] len;
        cause = t_stop_cause'($urandom_range(0, 3));
        case (cause)
            STOP_UNMASKED: begin
                len = wsfd_pkg::LenW'($urandom_range(0, 300));
                send_frame(4'($urandom_range(0, 15)), wsfd_pkg::OpcW'($urandom_range(0, 15)),
                           1'b0, len, pick_form(len));
            end
            STOP_TOO_LONG: begin
                if ($urandom_range(0, 1) == 0)
                    len = wsfd_pkg::LenW'(len_limit) + 1'b1;
                else
                    len = {1'b1, 31'($urandom), 32'($urandom)};
                send_frame(4'($urandom_range(0, 15)), OPC_BINARY, 1'b1, len, pick_form(len));
            end
            STOP_CLOSE_DATA: begin
                len = wsfd_pkg::LenW'($urandom_range(1, 10));
                send_frame(4'h8, wsfd_pkg::OPC_CLOSE, 1'b1, len, pick_form(len));
            end
            default: begin
                send_frame(4'h8, wsfd_pkg::OPC_CLOSE, 1'b1, '0, pick_form('0));
            end
        endcase
        // Everything after the stop must be swallowed.
        repeat (16)
            send_byte(wsfd_pkg::DataW'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frames();
        test_length_limits();
        test_random_stream();
        test_stream_stop();
        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && deframed_beats.size() == 0)
            $display("** websocket_frame_deframer: PASSED **");
        else
            $display("** websocket_frame_deframer: FAILED **");
        $finish;
    end

endmodule
